FILE: design/ltok_pkg.sv
// Shared types, character codes and keyword tables for the LOOP tokenizer.
`timescale 1ns / 1ps

package ltok_pkg;

  // Storage widths
  localparam int VALUE_BITS = 32;
  localparam int LINE_BITS  = 16;
  localparam int NEST_BITS  = 8;

  // Token queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Output tdata width: 69 bits of fields rounded up to whole bytes
  localparam int TDATA_BITS = 72;

  // Token kinds
  localparam logic [3:0] K_NAME   = 4'd0;
  localparam logic [3:0] K_NUMBER = 4'd1;
  localparam logic [3:0] K_LOOP   = 4'd2;
  localparam logic [3:0] K_DO     = 4'd3;
  localparam logic [3:0] K_END    = 4'd4;
  localparam logic [3:0] K_PLUS   = 4'd5;
  localparam logic [3:0] K_MINUS  = 4'd6;
  localparam logic [3:0] K_SEMI   = 4'd7;
  localparam logic [3:0] K_ASSIGN = 4'd8;
  localparam logic [3:0] K_EOF    = 4'd9;
  localparam logic [3:0] K_ERROR  = 4'd10;

  // Error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_BADCHAR  = 3'd1;
  localparam logic [2:0] E_NAMELONG = 3'd2;
  localparam logic [2:0] E_UNBAL    = 3'd3;
  localparam logic [2:0] E_IMPORT   = 3'd4;
  localparam logic [2:0] E_COLON    = 3'd5;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // Letter indexes of keyword starters
  localparam logic [4:0] LET_D = 5'd3;
  localparam logic [4:0] LET_E = 5'd4;
  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_L = 5'd11;

  // Lexer modes, one-hot
  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_NUMBER  = 8'b0000_0010,
    M_LETTER  = 8'b0000_0100,
    M_KEYWORD = 8'b0000_1000,
    M_NAME    = 8'b0001_0000,
    M_COLON   = 8'b0010_0000,
    M_SLASH   = 8'b0100_0000,
    M_COMMENT = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] number_value;
    logic [4:0]  name_letter;
    logic [1:0]  name_digit_count;
    logic [6:0]  name_number;
    logic [15:0] line_number;
    logic [2:0]  error_code;
  } tok_t;

  // One queue entry: the tokens caused by one character
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } entry_t;

  // Length of the keyword tail after its first letter; 0 for no keyword
  function automatic logic [2:0] kw_len(input logic [4:0] letter);
    logic [2:0] n;
    case (letter)
      LET_L:   n = 3'd3;
      LET_D:   n = 3'd1;
      LET_E:   n = 3'd2;
      LET_I:   n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Expected character at a position of the keyword tail
  function automatic logic [7:0] kw_char(input logic [4:0] letter, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (letter)
      LET_L: begin
        case (idx)
          3'd0:    ch = "O";
          3'd1:    ch = "O";
          3'd2:    ch = "P";
          default: ch = 8'h00;
        endcase
      end
      LET_D: begin
        ch = (idx == 3'd0) ? 8'("O") : 8'h00;
      end
      LET_E: begin
        case (idx)
          3'd0:    ch = "N";
          3'd1:    ch = "D";
          default: ch = 8'h00;
        endcase
      end
      LET_I: begin
        case (idx)
          3'd0:    ch = "M";
          3'd1:    ch = "P";
          3'd2:    ch = "O";
          3'd3:    ch = "R";
          3'd4:    ch = "T";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [31:0] value,
                                  input logic [4:0] letter, input logic [1:0] dcnt,
                                  input logic [6:0] num, input logic [15:0] line,
                                  input logic [2:0] code);
    tok_t t;
    t.kind             = kind;
    t.number_value     = value;
    t.name_letter      = letter;
    t.name_digit_count = dcnt;
    t.name_number      = num;
    t.line_number      = line;
    t.error_code       = code;
    return t;
  endfunction

endpackage

FILE: design/ltok_front.sv
// Front end: takes one character per beat, runs the lexer state and builds token entries.
`timescale 1ns / 1ps

module ltok_front
  import ltok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       q_full,
  output logic       push_valid,
  output entry_t     push_entry
);

  mode_t                 mode, mode_next;
  logic [4:0]            letter, letter_next;
  logic [2:0]            kprog, kprog_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [1:0]            dcnt, dcnt_next;
  logic [NEST_BITS-1:0]  depth, depth_next;
  logic [LINE_BITS-1:0]  line, line_next;
  logic                  halted, halted_next;

  logic                  fire;
  logic                  a_v, b_v;
  tok_t                  a_tok, b_tok;

  // Zero-extended views so the fixed output widths work at any storage width
  logic [VALUE_BITS+31:0] acc_wide;
  logic [LINE_BITS+15:0]  line_wide;
  logic [31:0]            acc_out;
  logic [15:0]            line_out;

  assign acc_wide  = {32'd0, acc};
  assign line_wide = {16'd0, line};
  assign acc_out   = acc_wide[31:0];
  assign line_out  = line_wide[15:0];

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready && !halted;

  // Lexer step
  always_comb begin
    logic                  num_char, is_letter;
    logic [3:0]            dig;
    logic [4:0]            lidx;
    logic [VALUE_BITS+3:0] acc10;
    logic                  use_idle, kw_done;
    mode_t                 i_mode;
    logic                  i_v, i_halt, i_line_inc;
    tok_t                  i_tok;
    logic [2:0]            klen;

    num_char  = char_code inside {[CH_0:CH_9]};
    is_letter = char_code inside {[CH_A:CH_Z]};
    dig       = char_code[3:0];
    lidx      = 5'(char_code - CH_A);
    acc10     = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (VALUE_BITS+4)'(dig);
    klen      = kw_len(letter);
    use_idle  = 1'b0;
    kw_done   = 1'b0;

    mode_next   = mode;
    letter_next = letter;
    kprog_next  = kprog;
    acc_next    = acc;
    dcnt_next   = dcnt;
    depth_next  = depth;
    line_next   = line;
    halted_next = halted;
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_tok       = '0;
    b_tok       = '0;

    // Character with nothing pending
    i_mode     = M_IDLE;
    i_v        = 1'b0;
    i_halt     = 1'b0;
    i_line_inc = 1'b0;
    i_tok      = '0;
    if (num_char) begin
      i_mode = M_NUMBER;
    end else if (is_letter) begin
      i_mode = M_LETTER;
    end else begin
      case (char_code)
        CH_LF:                  i_line_inc = 1'b1;
        CH_SPACE, CH_CR, CH_TAB: i_v = 1'b0;
        CH_PLUS: begin
          i_v   = 1'b1;
          i_tok = mk_tok(K_PLUS, '0, '0, '0, '0, line_out, E_NONE);
        end
        CH_MINUS: begin
          i_v   = 1'b1;
          i_tok = mk_tok(K_MINUS, '0, '0, '0, '0, line_out, E_NONE);
        end
        CH_SEMI: begin
          i_v   = 1'b1;
          i_tok = mk_tok(K_SEMI, '0, '0, '0, '0, line_out, E_NONE);
        end
        CH_COLON: i_mode = M_COLON;
        CH_SLASH: i_mode = M_SLASH;
        CH_NUL: begin
          i_v    = 1'b1;
          i_halt = 1'b1;
          if (depth != '0) begin
            i_tok = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_UNBAL);
          end else begin
            i_tok = mk_tok(K_EOF, '0, '0, '0, '0, line_out, E_NONE);
          end
        end
        default: begin
          i_v    = 1'b1;
          i_halt = 1'b1;
          i_tok  = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_BADCHAR);
        end
      endcase
    end

    case (mode)
      M_NUMBER: begin
        if (num_char) begin
          acc_next = (acc10[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1 : acc10[VALUE_BITS-1:0];
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(K_NUMBER, acc_out, '0, '0, '0, line_out, E_NONE);
          use_idle = 1'b1;
        end
      end
      M_NAME: begin
        if (num_char) begin
          if (dcnt >= 2'd2) begin
            a_v         = 1'b1;
            a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_NAMELONG);
            halted_next = 1'b1;
            mode_next   = M_IDLE;
          end else begin
            acc_next  = acc10[VALUE_BITS-1:0];
            dcnt_next = 2'd2;
          end
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(K_NAME, '0, letter, dcnt, acc[6:0], line_out, E_NONE);
          use_idle = 1'b1;
        end
      end
      M_LETTER: begin
        if (num_char) begin
          acc_next  = VALUE_BITS'(dig);
          dcnt_next = 2'd1;
          mode_next = M_NAME;
        end else if (klen != 3'd0 && char_code == kw_char(letter, 3'd0)) begin
          kprog_next = 3'd1;
          if (klen == 3'd1) begin
            kw_done = 1'b1;
          end else begin
            mode_next = M_KEYWORD;
          end
        end else if (klen != 3'd0 && letter != LET_I) begin
          // lone L, D or E: dropped, character handled afresh
          use_idle = 1'b1;
        end else begin
          a_v         = 1'b1;
          a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_BADCHAR);
          halted_next = 1'b1;
          mode_next   = M_IDLE;
        end
      end
      M_KEYWORD: begin
        if (kprog < klen && char_code == kw_char(letter, kprog)) begin
          kprog_next = kprog + 3'd1;
          if (kprog + 3'd1 == klen) begin
            kw_done = 1'b1;
          end
        end else begin
          a_v         = 1'b1;
          a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_BADCHAR);
          halted_next = 1'b1;
          mode_next   = M_IDLE;
        end
      end
      M_COLON: begin
        a_v       = 1'b1;
        mode_next = M_IDLE;
        if (char_code == CH_EQ) begin
          a_tok = mk_tok(K_ASSIGN, '0, '0, '0, '0, line_out, E_NONE);
        end else begin
          a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_COLON);
          halted_next = 1'b1;
        end
      end
      M_SLASH: begin
        if (char_code == CH_SLASH) begin
          mode_next = M_COMMENT;
        end else begin
          a_v         = 1'b1;
          a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_BADCHAR);
          halted_next = 1'b1;
          mode_next   = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (char_code == CH_LF || char_code == CH_NUL) begin
          use_idle = 1'b1;
        end
      end
      default: use_idle = 1'b1;
    endcase

    // Completed keyword
    if (kw_done) begin
      mode_next = M_IDLE;
      a_v       = 1'b1;
      case (letter)
        LET_L: begin
          depth_next = depth + 1'b1;
          a_tok      = mk_tok(K_LOOP, '0, '0, '0, '0, line_out, E_NONE);
        end
        LET_D: a_tok = mk_tok(K_DO, '0, '0, '0, '0, line_out, E_NONE);
        LET_E: begin
          depth_next = depth - 1'b1;
          a_tok      = mk_tok(K_END, '0, '0, '0, '0, line_out, E_NONE);
        end
        default: begin
          a_tok       = mk_tok(K_ERROR, '0, '0, '0, '0, line_out, E_IMPORT);
          halted_next = 1'b1;
        end
      endcase
    end

    // Fresh handling of the character
    if (use_idle) begin
      mode_next = i_mode;
      b_v       = i_v;
      b_tok     = i_tok;
      if (i_halt) begin
        halted_next = 1'b1;
      end
      if (i_line_inc && line != '1) begin
        line_next = line + 1'b1;
      end
      if (num_char) begin
        acc_next = VALUE_BITS'(dig);
      end
      if (is_letter) begin
        letter_next = lidx;
        kprog_next  = 3'd0;
      end
    end
  end

  // Queue entry
  assign push_valid      = fire && (a_v || b_v);
  assign push_entry.two  = a_v && b_v;
  assign push_entry.tok0 = a_v ? a_tok : b_tok;
  assign push_entry.tok1 = b_tok;

  // Lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      letter <= '0;
      kprog  <= '0;
      acc    <= '0;
      dcnt   <= '0;
      depth  <= '0;
      line   <= LINE_BITS'(1);
      halted <= 1'b0;
    end else if (fire) begin
      mode   <= mode_next;
      letter <= letter_next;
      kprog  <= kprog_next;
      acc    <= acc_next;
      dcnt   <= dcnt_next;
      depth  <= depth_next;
      line   <= line_next;
      halted <= halted_next;
    end
  end

endmodule

FILE: design/ltok_fifo.sv
// Short queue of token entries between the front and back ends.
`timescale 1ns / 1ps

module ltok_fifo
  import ltok_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  entry_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/ltok_back.sv
// Back end: splits queue entries into single token beats behind an output register.
`timescale 1ns / 1ps

module ltok_back
  import ltok_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  entry_t q_entry,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output tok_t   out_tok,
  output logic   out_last
);

  logic advance;
  logic pend_valid;
  tok_t pend_tok;

  // Output register is free when empty or being taken this cycle
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && !pend_valid && !q_empty;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        out_tok  <= pend_tok;
        out_last <= 1'b1;
      end else if (!q_empty) begin
        out_tok  <= q_entry.tok0;
        out_last <= !q_entry.two;
        pend_tok <= q_entry.tok1;
      end
    end
  end

endmodule

FILE: design/loop_language_tokenizer_core.sv
// Top level of the LOOP language tokenizer: front end, token queue and back end.
`timescale 1ns / 1ps
//
// Source bytes enter on the s_ channel, one byte per beat in s_tdata[7:0];
// a zero byte marks the end of the text. Tokens leave on the m_ channel,
// one token per beat, with m_tlast set on the last token caused by a byte.
// A byte causes zero, one or two tokens.
// m_tvalid rises when the byte's queue entry reaches the output register.
// Bytes are taken one per cycle while the queue is not full; a byte giving
// two tokens leaves as two beats from the single output register of the back end.
// The front end keeps the lexer state and writes each byte's tokens as one
// entry into a four-entry queue; the back end drains the queue.
// When the receiver stalls, the output beat holds and the queue fills;
// s_tready drops only when the queue is full.
// After an error or end-of-file token the block keeps taking bytes but
// produces nothing until reset.
// Reset (rst, synchronous) empties the queue and output register and puts
// the lexer in idle with line count one and nesting depth zero.

module loop_language_tokenizer_core
  import ltok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] char_code
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [3:0] token_kind, [35:4] number_value, [40:36] name_letter,
  // [42:41] name_digit_count, [49:43] name_number, [65:50] line_number,
  // [68:66] error_code, [71:69] zero
  output logic [TDATA_BITS-1:0] m_tdata,
  output logic                  m_tlast
);

  logic   push_valid, q_full, q_empty, q_pop;
  entry_t push_entry, q_entry;
  tok_t   out_tok;

  ltok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .char_code  (s_tdata),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  ltok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .empty      (q_empty)
  );

  ltok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok),
    .out_last  (m_tlast)
  );

  // Field packing, first field lowest
  assign m_tdata = {3'd0, out_tok.error_code, out_tok.line_number, out_tok.name_number,
                    out_tok.name_digit_count, out_tok.name_letter, out_tok.number_value,
                    out_tok.kind};

endmodule

FILE: design/ltok_check.sv
// Port-level checker for the LOOP tokenizer and its bind to the top level.
`timescale 1ns / 1ps

module ltok_check
  import ltok_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_BITS-1:0] m_tdata,
  input logic                  m_tlast
);

  logic [3:0] kind;
  logic [2:0] code;
  logic [1:0] dcnt;

  assign kind = m_tdata[3:0];
  assign dcnt = m_tdata[42:41];
  assign code = m_tdata[68:66];

  // Reset leaves no beat on the output
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat present right after reset");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // Error code is set on error tokens and only there
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((kind == K_ERROR) == (code != E_NONE)))
    else $error("error code does not match token kind");

  // Error and end-of-file tokens close their byte's burst
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (kind == K_ERROR || kind == K_EOF) |-> m_tlast)
    else $error("error or eof token without tlast");

  // Names carry one or two digits
  a_name_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == K_NAME |-> (dcnt == 2'd1 || dcnt == 2'd2))
    else $error("name token with bad digit count");

endmodule

bind loop_language_tokenizer_core ltok_check u_ltok_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: bench/ltok_token_checker.sv
// Token scoreboard: shadows the lexer on accepted bytes and checks every output beat.
`timescale 1ns / 1ps

module ltok_token_checker
  import ltok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] char_code
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_BITS-1:0] m_tdata,   // token fields, kind in [3:0]
  input  logic                  m_tlast,
  output int                    mismatches,
  output int                    tokens_pending
);

  typedef struct packed {
    logic last;
    tok_t tok;
  } exp_tok_t;

  exp_tok_t expected_tokens[$];
  tok_t     char_tokens[$];   // tokens caused by the byte being lexed

  // Shadow lexer state
  mode_t       lex_mode;
  logic [4:0]  cur_letter;
  logic [2:0]  kw_pos;
  logic [31:0] acc;
  logic [1:0]  name_digits;
  logic [7:0]  depth;
  logic [15:0] line_no;
  logic        halted;

  initial begin
    mismatches     = 0;
    tokens_pending = 0;
  end

  // Remaining letters of the keyword a letter starts; empty if none
  function automatic string kw_tail(input logic [4:0] letter);
    case (letter)
      LET_L:   return "OOP";
      LET_D:   return "O";
      LET_E:   return "ND";
      LET_I:   return "MPORT";
      default: return "";
    endcase
  endfunction

  // Decimal shift-in, saturating at the 32-bit ceiling
  function automatic logic [31:0] acc_push(input logic [31:0] a, input logic [3:0] d);
    longint unsigned wide;
    wide = 64'(a) * 64'd10 + 64'(d);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  function automatic tok_t token_here(input logic [3:0] kind, input logic [31:0] value,
                                      input logic [4:0] letter, input logic [1:0] cnt,
                                      input logic [6:0] num, input logic [2:0] code);
    tok_t t;
    t.kind             = kind;
    t.number_value     = value;
    t.name_letter      = letter;
    t.name_digit_count = cnt;
    t.name_number      = num;
    t.line_number      = line_no;
    t.error_code       = code;
    return t;
  endfunction

  function automatic string tok_str(input tok_t t, input logic last);
    return $sformatf("kind=%0d val=%0d let=%0d cnt=%0d num=%0d line=%0d err=%0d last=%0b",
                     t.kind, t.number_value, t.name_letter, t.name_digit_count,
                     t.name_number, t.line_number, t.error_code, last);
  endfunction

  task automatic put_simple(input logic [3:0] kind);
    char_tokens.push_back(token_here(kind, '0, '0, '0, '0, E_NONE));
  endtask

  // Errors halt the lexer until reset
  task automatic put_error(input logic [2:0] code);
    char_tokens.push_back(token_here(K_ERROR, '0, '0, '0, '0, code));
    halted   = 1'b1;
    lex_mode = M_IDLE;
  endtask

  // Byte seen with nothing pending
  task automatic idle_char(input logic [7:0] c);
    lex_mode = M_IDLE;
    if (c >= CH_0 && c <= CH_9) begin
      acc      = 32'(c - CH_0);
      lex_mode = M_NUMBER;
    end else if (c >= CH_A && c <= CH_Z) begin
      cur_letter = 5'(c - CH_A);
      kw_pos     = '0;
      lex_mode   = M_LETTER;
    end else begin
      case (c)
        CH_LF: begin
          if (line_no != 16'hFFFF) line_no++;
        end
        CH_SPACE, CH_CR, CH_TAB: begin
        end
        CH_PLUS:  put_simple(K_PLUS);
        CH_MINUS: put_simple(K_MINUS);
        CH_SEMI:  put_simple(K_SEMI);
        CH_COLON: lex_mode = M_COLON;
        CH_SLASH: lex_mode = M_SLASH;
        CH_NUL: begin
          if (depth != 0) begin
            put_error(E_UNBAL);
          end else begin
            put_simple(K_EOF);
            halted = 1'b1;
          end
        end
        default: put_error(E_BADCHAR);
      endcase
    end
  endtask

  // Whole keyword matched
  task automatic keyword_finish();
    lex_mode = M_IDLE;
    case (cur_letter)
      LET_L: begin
        depth++;
        put_simple(K_LOOP);
      end
      LET_D: put_simple(K_DO);
      LET_E: begin
        depth--;
        put_simple(K_END);
      end
      default: put_error(E_IMPORT);
    endcase
  endtask

  // One accepted byte: advance the shadow lexer and queue the tokens it causes
  task automatic lex_char(input logic [7:0] c);
    logic     num_char;
    string    tail;
    exp_tok_t want;
    char_tokens.delete();
    if (halted) return;
    num_char = (c >= CH_0 && c <= CH_9);
    tail     = kw_tail(cur_letter);
    case (lex_mode)
      M_NUMBER: begin
        if (num_char) begin
          acc = acc_push(acc, 4'(c - CH_0));
        end else begin
          char_tokens.push_back(token_here(K_NUMBER, acc, '0, '0, '0, E_NONE));
          idle_char(c);
        end
      end
      M_NAME: begin
        if (num_char) begin
          if (name_digits >= 2) begin
            put_error(E_NAMELONG);
          end else begin
            acc         = acc * 10 + 32'(c - CH_0);
            name_digits = 2'd2;
          end
        end else begin
          char_tokens.push_back(token_here(K_NAME, '0, cur_letter, name_digits, acc[6:0],
                                           E_NONE));
          idle_char(c);
        end
      end
      M_LETTER: begin
        if (num_char) begin
          acc         = 32'(c - CH_0);
          name_digits = 2'd1;
          lex_mode    = M_NAME;
        end else if (tail.len() != 0 && c == 8'(tail[0])) begin
          kw_pos = 3'd1;
          if (tail.len() == 1) keyword_finish();
          else lex_mode = M_KEYWORD;
        end else if (tail.len() != 0 && cur_letter != LET_I) begin
          // lone keyword letter is dropped
          idle_char(c);
        end else begin
          put_error(E_BADCHAR);
        end
      end
      M_KEYWORD: begin
        if (kw_pos < tail.len() && c == 8'(tail[kw_pos])) begin
          kw_pos++;
          if (kw_pos == tail.len()) keyword_finish();
        end else begin
          put_error(E_BADCHAR);
        end
      end
      M_COLON: begin
        if (c == CH_EQ) begin
          put_simple(K_ASSIGN);
          lex_mode = M_IDLE;
        end else begin
          put_error(E_COLON);
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) lex_mode = M_COMMENT;
        else put_error(E_BADCHAR);
      end
      M_COMMENT: begin
        if (c == CH_LF || c == CH_NUL) idle_char(c);
      end
      default: idle_char(c);
    endcase
    foreach (char_tokens[i]) begin
      want.tok  = char_tokens[i];
      want.last = (i == char_tokens.size() - 1);
      expected_tokens.push_back(want);
    end
  endtask

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  // Predict on the input side, compare on the output side
  always @(posedge clk) begin : watch
    tok_t     got;
    exp_tok_t want;
    if (rst) begin
      lex_mode    = M_IDLE;
      cur_letter  = '0;
      kw_pos      = '0;
      acc         = '0;
      name_digits = '0;
      depth       = '0;
      line_no     = 16'd1;
      halted      = 1'b0;
      expected_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) lex_char(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind             = m_tdata[3:0];
        got.number_value     = m_tdata[35:4];
        got.name_letter      = m_tdata[40:36];
        got.name_digit_count = m_tdata[42:41];
        got.name_number      = m_tdata[49:43];
        got.line_number      = m_tdata[65:50];
        got.error_code       = m_tdata[68:66];
        if (expected_tokens.size() == 0) begin
          flag({"unexpected token: ", tok_str(got, m_tlast)});
        end else begin
          want = expected_tokens.pop_front();
          if (want.tok.kind !== got.kind ||
              want.tok.number_value !== got.number_value ||
              want.tok.name_letter !== got.name_letter ||
              want.tok.name_digit_count !== got.name_digit_count ||
              want.tok.name_number !== got.name_number ||
              want.tok.line_number !== got.line_number ||
              want.tok.error_code !== got.error_code ||
              want.last !== m_tlast)
            flag({"token mismatch: expected ", tok_str(want.tok, want.last),
                  " got ", tok_str(got, m_tlast)});
        end
      end
    end
    tokens_pending <= expected_tokens.size();
  end

endmodule

FILE: bench/tb_loop_language_tokenizer_core.sv
// Testbench top for the tokenizer: source text generator, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_loop_language_tokenizer_core;
  import ltok_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TEXT_BYTES  = 560;
  localparam int HOLD_CYCLES = 300;

  typedef enum {
    FR_NUMBER, FR_NAME, FR_LOOP, FR_DO, FR_END, FR_LONE, FR_SYMBOL, FR_COMMENT, FR_BLANK
  } frag_t;

  // How the text ends; every ending halts the lexer
  typedef enum {
    ED_EOF, ED_OPEN, ED_BADCHAR, ED_LONE, ED_LONG, ED_IMPORT, ED_COLON, ED_SLASH,
    ED_MISMATCH
  } ending_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tlast;
  int                    mismatches;
  int                    tokens_pending;

  int         burst_left = 0;
  int         bytes_sent = 0;
  logic [7:0] open_loops = '0;
  bit         hold_asked = 1'b0;
  int         hold_left  = 0;
  int         phase_left = 0;
  logic [7:0] ready_pattern = 8'hFF;
  logic [2:0] pat_pos = '0;
  int         cycles = 0;

  always #5 clk = ~clk;

  loop_language_tokenizer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ltok_token_checker tok_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .tokens_pending (tokens_pending)
  );

  // Receiver: phases of random ready patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_asked) begin
      hold_asked = 1'b0;
      hold_left  = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 8'hFF;
          1:       ready_pattern = 8'($urandom);
          2:       ready_pattern = 8'($urandom & $urandom);
          default: ready_pattern = 8'($urandom | $urandom);
        endcase
        if (ready_pattern == 8'h00) ready_pattern = 8'h01;
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      pat_pos++;
      m_tready <= ready_pattern[pat_pos];
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One byte on the input channel; bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
  endtask

  // Sender pause until every predicted token has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Separator that cannot extend a name or a lone letter
  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 6))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_SEMI;
      default: return pick_blank();
    endcase
  endfunction

  // Bytes that can start something legal at idle
  function automatic bit starts_lexeme(input logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || (b >= CH_A && b <= CH_Z) || b == CH_LF ||
           b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_PLUS || b == CH_MINUS ||
           b == CH_SEMI || b == CH_COLON || b == CH_SLASH || b == CH_NUL;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic frag_t pick_frag();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return FR_NUMBER;
    if (r < 8) return FR_NAME;
    if (r < 10) return FR_LOOP;
    if (r < 11) return FR_DO;
    if (r < 12) return FR_END;
    if (r < 13) return FR_LONE;
    if (r < 17) return FR_SYMBOL;
    if (r < 18) return FR_COMMENT;
    return FR_BLANK;
  endfunction

  task automatic send_number();
    if ($urandom_range(0, 15) == 0) begin
      send_str($urandom_range(0, 1) ? "4294967295" : "4294967294");
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    repeat ($urandom_range(4, 9)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
        2:       repeat ($urandom_range(10, 12)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
        default: repeat ($urandom_range(1, 3)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic send_name();
    send_byte(8'(CH_A + $urandom_range(0, 25)));
    repeat ($urandom_range(1, 2)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
  endtask

  task automatic send_lone();
    case ($urandom_range(0, 2))
      0:       send_str("L");
      1:       send_str("D");
      default: send_str("E");
    endcase
  endtask

  // Comment body takes any byte but newline and end of text
  task automatic send_comment(input bit close);
    logic [7:0] b;
    send_str("//");
    repeat ($urandom_range(0, 10)) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
      send_byte(b);
    end
    if (close) send_byte(CH_LF);
  endtask

  // One well-formed piece of source text with a separator where needed
  task automatic send_fragment();
    frag_t f;
    f = pick_frag();
    case (f)
      FR_NUMBER: send_number();
      FR_NAME:   send_name();
      FR_LOOP: begin
        send_str("LOOP");
        open_loops++;
      end
      FR_DO: send_str("DO");
      FR_END: begin
        if (open_loops != 0) begin
          send_str("END");
          open_loops--;
        end else begin
          send_str("LOOP");
          open_loops++;
        end
      end
      FR_LONE: send_lone();
      FR_SYMBOL: begin
        case ($urandom_range(0, 3))
          0:       send_str("+");
          1:       send_str("-");
          2:       send_str(";");
          default: send_str(":=");
        endcase
      end
      FR_COMMENT: send_comment(1'b1);
      default:    repeat ($urandom_range(1, 3)) send_byte(pick_blank());
    endcase
    if (f == FR_NAME || f == FR_LONE) send_byte(pick_sep());
    else if ($urandom_range(0, 1) == 0) send_byte(pick_blank());
  endtask

  task automatic close_loops();
    while (open_loops != 0) begin
      send_str("END ");
      open_loops--;
    end
  endtask

  // Final stretch of text, ending in end of file or in one of the errors
  task automatic send_ending(input ending_t e);
    logic [7:0] b;
    case (e)
      ED_EOF: begin
        close_loops();
        case ($urandom_range(0, 4))
          0:       send_number();
          1:       send_name();
          2:       send_comment(1'b0);
          3:       send_lone();
          default: send_byte(pick_blank());
        endcase
        send_byte(CH_NUL);
      end
      ED_OPEN: begin
        if (open_loops == 0) send_str("LOOP ");
        send_byte(CH_NUL);
      end
      ED_BADCHAR: begin
        do b = 8'($urandom_range(1, 255)); while (starts_lexeme(b));
        send_byte(b);
      end
      ED_LONE: begin
        do b = 8'(CH_A + $urandom_range(0, 25));
        while (b == "D" || b == "E" || b == "I" || b == "L");
        send_byte(b);
        do b = 8'($urandom_range(0, 255)); while (b >= CH_0 && b <= CH_9);
        send_byte(b);
      end
      ED_LONG: begin
        send_byte(8'(CH_A + $urandom_range(0, 25)));
        repeat (3) send_byte(8'(CH_0 + $urandom_range(0, 9)));
      end
      ED_IMPORT: send_str("IMPORT");
      ED_COLON: begin
        send_byte(CH_COLON);
        send_byte(byte_other_than(CH_EQ));
      end
      ED_SLASH: begin
        send_byte(CH_SLASH);
        send_byte(byte_other_than(CH_SLASH));
      end
      default: begin
        // keyword broken after its first letters
        case ($urandom_range(0, 4))
          0: begin
            send_str("LO");
            send_byte(byte_other_than("O"));
          end
          1: begin
            send_str("LOO");
            send_byte(byte_other_than("P"));
          end
          2: begin
            send_str("EN");
            send_byte(byte_other_than("D"));
          end
          3: begin
            // a digit would turn the I into a name
            send_str("I");
            do b = 8'($urandom_range(0, 255));
            while (b == "M" || (b >= CH_0 && b <= CH_9));
            send_byte(b);
          end
          default: begin
            send_str("IMPO");
            send_byte(byte_other_than("R"));
          end
        endcase
      end
    endcase
  endtask

  initial begin
    bit      held;
    bit      drained;
    ending_t ending;
    held    = 1'b0;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed text: zero, saturating number, name extremes, LOOP, DO, END, all symbols,
    // a dropped lone letter and a comment holding a high byte
    send_str("0;4294967296Z99-A1:=LOOPDOENDL+//");
    send_byte(8'hFF);
    send_byte(CH_LF);

    // Random well-formed text with one long output hold-off and one drain pause
    while (bytes_sent < TEXT_BYTES) begin
      send_fragment();
      if (!held && bytes_sent >= 200) begin
        hold_asked = 1'b1;
        held       = 1'b1;
      end
      if (!drained && bytes_sent >= 400) begin
        wait_drained();
        drained = 1'b1;
      end
    end

    // A little more text, then the ending
    repeat (20) send_fragment();

    ending = ending_t'($urandom_range(0, int'(ED_MISMATCH)));
    send_ending(ending);

    // Halted lexer must stay silent
    repeat (40) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && tokens_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
